// ===== rtl/nec_ir_pkg.sv =====
`default_nettype none

package nec_ir_pkg;

  // Capture tick rate: ticks per 10 us.
  localparam int unsigned TICKS_PER_10US = 8;

  localparam int unsigned TickW  = 15;
  localparam int unsigned UsW    = 19;  // floor(32767 * 10 / 1) fits
  localparam int unsigned CmpW   = 20;  // us + margin, target + margin
  localparam int unsigned MarginW = 10;
  localparam int unsigned TimeW  = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned IdxW   = 6;
  localparam int unsigned WordW  = 16;

  localparam logic [IdxW-1:0] FrameItems = IdxW'(34);
  localparam logic [IdxW-1:0] LastBitIdx = IdxW'(32);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACTIVE_LEVEL = 3'd0,
    CFG_MARGIN       = 3'd1,
    CFG_HDR_MARK     = 3'd2,
    CFG_HDR_SPACE    = 3'd3,
    CFG_BIT_MARK     = 3'd4,
    CFG_ONE_SPACE    = 3'd5,
    CFG_ZERO_SPACE   = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SHORT  = 2'd1,
    ST_HEADER = 2'd2,
    ST_BIT    = 2'd3
  } status_e;

  typedef struct packed {
    logic               active_level;
    logic [MarginW-1:0] tol_us;
    logic [TimeW-1:0]   header_mark_us;
    logic [TimeW-1:0]   header_space_us;
    logic [TimeW-1:0]   bit_mark_us;
    logic [TimeW-1:0]   one_space_us;
    logic [TimeW-1:0]   zero_space_us;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    active_level:    1'b1,
    tol_us:          MarginW'(20),
    header_mark_us:  TimeW'(9000),
    header_space_us: TimeW'(4500),
    bit_mark_us:     TimeW'(560),
    one_space_us:    TimeW'(1690),
    zero_space_us:   TimeW'(560)
  };

  // Classified pulse item as passed from front to back.
  typedef struct packed {
    logic hdr_ok;
    logic one_ok;
    logic zero_ok;
    logic last;
  } cls_t;

endpackage

`default_nettype wire

// ===== rtl/nec_ir_front.sv =====
`default_nettype none

module nec_ir_front (
  input  wire nec_ir_pkg::cfg_t           cfg_i,
  input  wire logic                       level_first_i,
  input  wire logic [nec_ir_pkg::TickW-1:0] duration_first_i,
  input  wire logic                       level_second_i,
  input  wire logic [nec_ir_pkg::TickW-1:0] duration_second_i,
  input  wire logic                       last_i,
  output nec_ir_pkg::cls_t                cls_o
);
  import nec_ir_pkg::*;

  logic [UsW-1:0] us_first, us_second;
  logic           shape_ok;
  logic           mark_hdr, mark_bit, space_hdr, space_one, space_zero;

  function automatic logic [UsW-1:0] to_us(input logic [TickW-1:0] ticks);
    logic [UsW-1:0] prod;
    prod = UsW'(ticks) * UsW'(10);
    return UsW'(prod / TICKS_PER_10US);
  endfunction

  // Strict window: target - m < us < target + m, kept non-negative.
  function automatic logic near(input logic [UsW-1:0] us,
                                input logic [TimeW-1:0] target,
                                input logic [MarginW-1:0] margin);
    logic [CmpW-1:0] hi, us_m;
    hi   = CmpW'(target) + CmpW'(margin);
    us_m = CmpW'(us) + CmpW'(margin);
    return (CmpW'(us) < hi) && (us_m > CmpW'(target));
  endfunction

  always_comb begin
    us_first   = to_us(duration_first_i);
    us_second  = to_us(duration_second_i);
    shape_ok   = (level_first_i == cfg_i.active_level) &&
                 (level_second_i != cfg_i.active_level);
    mark_hdr   = near(us_first, cfg_i.header_mark_us, cfg_i.tol_us);
    mark_bit   = near(us_first, cfg_i.bit_mark_us, cfg_i.tol_us);
    space_hdr  = near(us_second, cfg_i.header_space_us, cfg_i.tol_us);
    space_one  = near(us_second, cfg_i.one_space_us, cfg_i.tol_us);
    space_zero = near(us_second, cfg_i.zero_space_us, cfg_i.tol_us);

    cls_o.hdr_ok  = shape_ok && mark_hdr && space_hdr;
    cls_o.one_ok  = shape_ok && mark_bit && space_one;
    cls_o.zero_ok = shape_ok && mark_bit && space_zero;
    cls_o.last    = last_i;
  end

endmodule

`default_nettype wire

// ===== rtl/nec_ir_fifo.sv =====
`default_nettype none

module nec_ir_fifo (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire nec_ir_pkg::cls_t data_i,
  output logic             full_o,
  input  wire logic        pop_i,
  output logic             valid_o,
  output nec_ir_pkg::cls_t data_o
);
  import nec_ir_pkg::*;

  cls_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    full_o   = (cnt_q == 2'd2);
    valid_o  = (cnt_q != 2'd0);
    data_o   = mem_q[rd_ptr_q];
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/nec_ir_back.sv =====
`default_nettype none

module nec_ir_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  input  wire nec_ir_pkg::cls_t              cls_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output nec_ir_pkg::status_e                status_o,
  output logic [nec_ir_pkg::WordW-1:0]       address_o,
  output logic [nec_ir_pkg::WordW-1:0]       command_o
);
  import nec_ir_pkg::*;

  logic [IdxW-1:0]  idx_q, idx_d;
  logic [WordW-1:0] addr_q, addr_d, cmd_q, cmd_d;
  status_e          err_q, err_d;

  logic             oval_q, oval_d;
  status_e          ost_q, ost_d;
  logic [WordW-1:0] oaddr_q, oaddr_d, ocmd_q, ocmd_d;

  logic [3:0]       pos;
  logic [IdxW-1:0]  idx_inc;
  status_e          err_n;
  logic [WordW-1:0] addr_n, cmd_n;

  // Non-last items never touch the output stage.
  assign pop_o = valid_i && (!cls_i.last || !oval_q || out_ready_i);

  always_comb begin
    pos     = idx_q[3:0] - 4'd1;
    err_n   = err_q;
    addr_n  = addr_q;
    cmd_n   = cmd_q;
    idx_inc = (idx_q < FrameItems) ? idx_q + IdxW'(1) : idx_q;

    if (err_q == ST_OK) begin
      if (idx_q == '0) begin
        if (!cls_i.hdr_ok) err_n = ST_HEADER;
      end else if (idx_q <= LastBitIdx) begin
        if (!cls_i.one_ok && !cls_i.zero_ok) begin
          err_n = ST_BIT;
        end else if (cls_i.one_ok) begin
          if (idx_q <= IdxW'(16)) addr_n[pos] = 1'b1;
          else                    cmd_n[pos]  = 1'b1;
        end
      end
    end

    idx_d   = idx_q;
    err_d   = err_q;
    addr_d  = addr_q;
    cmd_d   = cmd_q;
    oval_d  = oval_q && !out_ready_i;
    ost_d   = ost_q;
    oaddr_d = oaddr_q;
    ocmd_d  = ocmd_q;

    if (pop_o) begin
      if (cls_i.last) begin
        idx_d  = '0;
        err_d  = ST_OK;
        addr_d = '0;
        cmd_d  = '0;
        oval_d = 1'b1;
        ost_d  = (idx_inc < FrameItems) ? ST_SHORT : err_n;
        oaddr_d = (ost_d == ST_OK) ? addr_n : '0;
        ocmd_d  = (ost_d == ST_OK) ? cmd_n  : '0;
      end else begin
        idx_d  = idx_inc;
        err_d  = err_n;
        addr_d = addr_n;
        cmd_d  = cmd_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      err_q  <= ST_OK;
      addr_q <= '0;
      cmd_q  <= '0;
      oval_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      err_q  <= err_d;
      addr_q <= addr_d;
      cmd_q  <= cmd_d;
      oval_q <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ost_q   <= ost_d;
    oaddr_q <= oaddr_d;
    ocmd_q  <= ocmd_d;
  end

  assign out_valid_o = oval_q;
  assign status_o    = ost_q;
  assign address_o   = oaddr_q;
  assign command_o   = ocmd_q;

endmodule

`default_nettype wire

// ===== rtl/nec_ir_pulse_decoder.sv =====
`default_nettype none

// NEC infrared frame decoder. Each input beat is one captured pulse (two
// levels, two 15-bit tick counts, tlast on the frame's final pulse); ticks
// become microseconds as floor(ticks*10/TICKS_PER_10US) and each half must
// sit strictly inside target +/- the tolerance register. Pulse 0 is the
// header, pulses 1..16 carry the address and 17..32 the command, LSB first;
// later pulses are ignored. One result beat leaves per frame, on its tlast
// pulse: status in tuser (0 ok, 1 short frame, 2 bad header, 3 bad bit) and
// address/command in tdata, both zero unless status is ok. Throughput is one
// pulse per clock unless a tlast pulse waits on a held result: the front
// classifies a pulse combinationally into a two-entry queue and the back folds
// one queued pulse per cycle into the frame state. An accepted tlast pulse
// reaches the result beat through the queue and then the result register.
// Configuration writes take effect at once and belong in idle periods only.

module nec_ir_pulse_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,

  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [0] level_first, [15:1] duration_first, [16] level_second,
  // [31:17] duration_second
  input  wire logic [31:0] s_axis_tdata,
  input  wire logic        s_axis_tlast,   // frame_last

  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [15:0] address, [31:16] command
  output logic [31:0]      m_axis_tdata,
  // [1:0] status
  output logic [1:0]       m_axis_tuser
);
  import nec_ir_pkg::*;

  cfg_t    cfg_q, cfg_d;
  cls_t    cls_in, cls_q;
  logic    fifo_full, fifo_valid, fifo_pop, in_beat;
  status_e status;
  logic [WordW-1:0] address, command;

  // Configuration registers; unknown indexes are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ACTIVE_LEVEL: cfg_d.active_level    = cfg_data_i[0];
        CFG_MARGIN:       cfg_d.tol_us          = cfg_data_i[MarginW-1:0];
        CFG_HDR_MARK:     cfg_d.header_mark_us  = cfg_data_i;
        CFG_HDR_SPACE:    cfg_d.header_space_us = cfg_data_i;
        CFG_BIT_MARK:     cfg_d.bit_mark_us     = cfg_data_i;
        CFG_ONE_SPACE:    cfg_d.one_space_us    = cfg_data_i;
        CFG_ZERO_SPACE:   cfg_d.zero_space_us   = cfg_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: classify the pulse against header / one / zero windows.
  nec_ir_front u_front (
    .cfg_i             (cfg_q),
    .level_first_i     (s_axis_tdata[0]),
    .duration_first_i  (s_axis_tdata[15:1]),
    .level_second_i    (s_axis_tdata[16]),
    .duration_second_i (s_axis_tdata[31:17]),
    .last_i            (s_axis_tlast),
    .cls_o             (cls_in)
  );

  assign s_axis_tready = !fifo_full;
  assign in_beat       = s_axis_tvalid && !fifo_full;

  nec_ir_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_beat),
    .data_i  (cls_in),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .valid_o (fifo_valid),
    .data_o  (cls_q)
  );

  // Back: frame sequencing, bit assembly and the result register.
  nec_ir_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (fifo_valid),
    .cls_i       (cls_q),
    .pop_o       (fifo_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_o    (status),
    .address_o   (address),
    .command_o   (command)
  );

  assign m_axis_tdata = {command, address};
  assign m_axis_tuser = status;

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import nec_ir_pkg::*;

  // Run shape
  localparam int ItemTarget   = 1900;  // pulse beats, directed and random together
  localparam int SettleCycles = 8;     // covers the result register plus the pulse queue
  localparam int QuietLimit   = 3000;  // cycles with no beat on either side before giving up
  localparam int HoldCycles   = 300;   // long receiver hold-off in the backpressure test

  // The write port has a spare index that the decoder must ignore.
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 3'd7;

  // Timing register sets applied between phases
  typedef enum int {
    TS_DEFAULT,
    TS_INVERTED,  // active level 0, margin clipped to its maximum
    TS_TIGHT,     // margin 1: only the exact target passes
    TS_EXTREME,   // margin 0, targets at full scale: nothing can pass
    TS_LOW,       // small targets, lower bounds below zero except the one-space window
    TS_RANDOM
  } timing_set_e;

  // One captured pulse as the capture unit hands it over
  typedef struct packed {
    logic        lvl_a;
    logic [14:0] ticks_a;
    logic        lvl_b;
    logic [14:0] ticks_b;
    logic        last;
  } pulse_t;

  // One decoded frame as it should leave the block
  typedef struct {
    status_e     status;
    logic [15:0] address;
    logic [15:0] command;
  } frame_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;

  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [0] level_first, [15:1] duration_first, [16] level_second,
  // [31:17] duration_second
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;   // frame_last

  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [15:0] address, [31:16] command
  logic [31:0] m_axis_tdata;
  // [1:0] status
  logic [1:0]  m_axis_tuser;

  nec_ir_pulse_decoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Decoder model: own copy of the timing registers and the frame state.
  // ---------------------------------------------------------------------------
  cfg_t          dec_cfg;
  int            frame_pos;     // pulses seen in this frame, stops at FrameItems
  logic [15:0]   addr_acc;
  logic [15:0]   cmd_acc;
  status_e       first_err;     // first error of the frame; later ones are dropped
  frame_result_t decoded_q[$];  // frames decoded but not yet seen on the output

  // Run bookkeeping
  int pulses_sent;
  int results_checked;
  int mismatches;
  int settings_applied;
  int status_seen[4];

  // Sender / receiver knobs
  int tx_burst_left;
  bit tx_steady;       // no gaps at all, used to fill the block
  int rx_hold_req;     // set by a test, picked up by the receiver process
  int rx_hold_left;
  int rx_mode;
  int rx_mode_left;
  int rx_cyc;
  logic [7:0] rx_pat;

  function automatic void clear_frame();
    frame_pos = 0;
    addr_acc  = '0;
    cmd_acc   = '0;
    first_err = ST_OK;
  endfunction

  // Strict window check in signed arithmetic; a negative lower bound lets
  // everything through from below.
  function automatic bit in_window(logic [14:0] ticks, logic [15:0] target);
    int us, lo, hi;
    us = (int'(ticks) * 10) / int'(TICKS_PER_10US);
    hi = int'(target) + int'(dec_cfg.tol_us);
    lo = int'(target) - int'(dec_cfg.tol_us);
    return (us > lo) && (us < hi);
  endfunction

  function automatic bit pulse_fits(pulse_t p, logic [15:0] mark, logic [15:0] space);
    return (p.lvl_a == dec_cfg.active_level) && (p.lvl_b != dec_cfg.active_level) &&
           in_window(p.ticks_a, mark) && in_window(p.ticks_b, space);
  endfunction

  // Fold one accepted pulse into the frame; on the marked pulse the frame
  // result is queued and the frame state cleared.
  function automatic void fold_pulse(pulse_t p);
    logic          bval;
    status_e       st;
    frame_result_t r;
    bval = 1'b0;
    if (first_err == ST_OK) begin
      if (frame_pos == 0) begin
        if (!pulse_fits(p, dec_cfg.header_mark_us, dec_cfg.header_space_us))
          first_err = ST_HEADER;
      end else if (frame_pos <= int'(LastBitIdx)) begin
        // a one is tried first, so overlapping windows decode as one
        if (pulse_fits(p, dec_cfg.bit_mark_us, dec_cfg.one_space_us)) begin
          bval = 1'b1;
        end else if (pulse_fits(p, dec_cfg.bit_mark_us, dec_cfg.zero_space_us)) begin
          bval = 1'b0;
        end else begin
          first_err = ST_BIT;
        end
        if (first_err == ST_OK) begin
          if (frame_pos <= int'(WordW)) addr_acc[frame_pos-1] = bval;
          else cmd_acc[frame_pos-1-int'(WordW)] = bval;
        end
      end
    end
    if (frame_pos < int'(FrameItems)) frame_pos++;
    if (p.last) begin
      // short frame wins over any header or bit error
      st = (frame_pos < int'(FrameItems)) ? ST_SHORT : first_err;
      r.status  = st;
      r.address = (st == ST_OK) ? addr_acc : '0;
      r.command = (st == ST_OK) ? cmd_acc : '0;
      decoded_q.push_back(r);
      clear_frame();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Pulse builders
  // ---------------------------------------------------------------------------
  // Rounds up, so the decoded value lands on us or us+1.
  function automatic logic [14:0] us_to_ticks(int us);
    int t;
    if (us <= 0) return '0;
    t = (us * int'(TICKS_PER_10US) + 9) / 10;
    return (t > 32767) ? 15'h7fff : 15'(t);
  endfunction

  // Random offset that stays inside the window after rounding.
  function automatic int jitter_us(int target);
    int m;
    m = int'(dec_cfg.tol_us);
    if (m < 3) return target;
    return target + int'($urandom_range(0, 2 * (m - 3))) - (m - 3);
  endfunction

  function automatic pulse_t pulse_of(logic [14:0] mark_t, logic [14:0] space_t);
    pulse_t p;
    p.lvl_a   = dec_cfg.active_level;
    p.ticks_a = mark_t;
    p.lvl_b   = ~dec_cfg.active_level;
    p.ticks_b = space_t;
    p.last    = 1'b0;
    return p;
  endfunction

  function automatic pulse_t good_header();
    return pulse_of(us_to_ticks(jitter_us(int'(dec_cfg.header_mark_us))),
                    us_to_ticks(jitter_us(int'(dec_cfg.header_space_us))));
  endfunction

  function automatic pulse_t good_bit(logic bval);
    return pulse_of(us_to_ticks(jitter_us(int'(dec_cfg.bit_mark_us))),
                    us_to_ticks(jitter_us(int'(bval ? dec_cfg.one_space_us
                                                    : dec_cfg.zero_space_us))));
  endfunction

  function automatic pulse_t noise_pulse();
    pulse_t p;
    p.lvl_a   = 1'($urandom);
    p.ticks_a = 15'($urandom);
    p.lvl_b   = 1'($urandom);
    p.ticks_b = 15'($urandom);
    p.last    = 1'b0;
    return p;
  endfunction

  // Near misses: wrong levels, or a half pushed onto / past a window edge.
  function automatic pulse_t broken_pulse(bit is_header);
    pulse_t p;
    int     mark, space, m;
    m     = int'(dec_cfg.tol_us);
    mark  = is_header ? int'(dec_cfg.header_mark_us) : int'(dec_cfg.bit_mark_us);
    space = is_header ? int'(dec_cfg.header_space_us) :
            ($urandom_range(0, 1) ? int'(dec_cfg.one_space_us) : int'(dec_cfg.zero_space_us));
    p = pulse_of(us_to_ticks(mark), us_to_ticks(space));
    case ($urandom_range(0, 4))
      0: begin
        p.lvl_a = ~p.lvl_a;
        p.lvl_b = ~p.lvl_b;
      end
      1: p.lvl_b = p.lvl_a;
      2: p.ticks_a = (mark - m <= 0) ? '0 : 15'(((mark - m) * int'(TICKS_PER_10US)) / 10);
      3: p.ticks_b = us_to_ticks(space + m);
      default: p = noise_pulse();
    endcase
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps in between.
  // ---------------------------------------------------------------------------
  task automatic send_pulse(input pulse_t p);
    int gap;
    if (!tx_steady && tx_burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      tx_burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                  : $urandom_range(1, 12);
    end
    if (tx_burst_left != 0) tx_burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {p.ticks_b, p.lvl_b, p.ticks_a, p.lvl_a};
    s_axis_tlast  <= p.last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pulses_sent++;
    fold_pulse(p);
  endtask

  // Header, 16 address bits, 16 command bits, then noise past the data.
  // bad_at replaces that pulse with a near miss; the final pulse is marked.
  task automatic send_frame(input pulse_t hdr, input logic [15:0] addr,
                            input logic [15:0] cmd, input int n_items, input int bad_at);
    pulse_t p;
    for (int i = 0; i < n_items; i++) begin
      if (i == 0) p = hdr;
      else if (i <= 16) p = good_bit(addr[i-1]);
      else if (i <= 32) p = good_bit(cmd[i-17]);
      else p = noise_pulse();
      if (i == bad_at) p = broken_pulse(i == 0);
      p.last = (i == n_items - 1);
      send_pulse(p);
    end
  endtask

  task automatic send_noise(input int n_items);
    pulse_t p;
    for (int i = 0; i < n_items; i++) begin
      p = noise_pulse();
      p.last = (i == n_items - 1);
      send_pulse(p);
    end
  endtask

  // Stop offering, let every pending frame out, then give pulses that
  // carry no result time to clear the pipe.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Register writes; only called with the block idle.
  // ---------------------------------------------------------------------------
  task automatic wr_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ACTIVE_LEVEL: dec_cfg.active_level    = val[0];
      CFG_MARGIN:       dec_cfg.tol_us          = val[MarginW-1:0];
      CFG_HDR_MARK:     dec_cfg.header_mark_us  = val;
      CFG_HDR_SPACE:    dec_cfg.header_space_us = val;
      CFG_BIT_MARK:     dec_cfg.bit_mark_us     = val;
      CFG_ONE_SPACE:    dec_cfg.one_space_us    = val;
      CFG_ZERO_SPACE:   dec_cfg.zero_space_us   = val;
      default: ;  // spare index, no register behind it
    endcase
    @(posedge clk_i);
  endtask

  task automatic apply_timing(input timing_set_e ts);
    logic [15:0] lvl, mrg, hm, hs, bm, os, zs;
    lvl = 16'd1;
    mrg = 16'd20;
    hm  = 16'd9000;
    hs  = 16'd4500;
    bm  = 16'd560;
    os  = 16'd1690;
    zs  = 16'd560;
    case (ts)
      TS_INVERTED: begin
        lvl = 16'hfffe;  // only bit 0 counts
        mrg = 16'hffff;  // clips to 1023
      end
      TS_TIGHT: mrg = 16'd1;
      TS_EXTREME: begin
        mrg = 16'hfc00;  // clips to 0, window empty
        hm  = 16'hffff;
        hs  = 16'hffff;
        bm  = 16'hffff;
        os  = 16'hffff;
        zs  = 16'hffff;
      end
      TS_LOW: begin
        lvl = 16'd0;
        mrg = 16'd200;
        hm  = 16'd50;
        hs  = 16'd150;
        bm  = 16'd0;
        os  = 16'd700;
        zs  = 16'd100;
      end
      TS_RANDOM: begin
        lvl = 16'($urandom);
        mrg = 16'($urandom_range(3, 300));
        hm  = 16'($urandom_range(0, 35000));
        hs  = 16'($urandom_range(0, 35000));
        bm  = 16'($urandom_range(0, 35000));
        os  = 16'($urandom_range(0, 35000));
        zs  = 16'($urandom_range(0, 35000));
      end
      default: ;
    endcase
    wr_reg(CFG_ACTIVE_LEVEL, lvl);
    wr_reg(CFG_MARGIN, mrg);
    wr_reg(CFG_HDR_MARK, hm);
    wr_reg(CFG_HDR_SPACE, hs);
    wr_reg(CFG_BIT_MARK, bm);
    wr_reg(CFG_ONE_SPACE, os);
    wr_reg(CFG_ZERO_SPACE, zs);
    wr_reg(CfgIdxSpare, 16'($urandom));
    settings_applied++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Frames that end early: field extremes on a lone pulse, errors that the
  // short status must hide.
  task automatic test_short_frames();
    pulse_t p;
    p = good_header();
    p.last = 1'b1;
    send_pulse(p);
    send_pulse('{1'b0, 15'h0000, 1'b0, 15'h0000, 1'b1});
    send_pulse('{1'b1, 15'h7fff, 1'b1, 15'h7fff, 1'b1});
    send_pulse('{1'b0, 15'h7fff, 1'b1, 15'h0000, 1'b1});
    send_pulse('{1'b1, 15'h0000, 1'b0, 15'h7fff, 1'b1});
    // bad header followed by a clean bit: still reported as short
    send_pulse('{1'b0, 15'h2aaa, 1'b1, 15'h5555, 1'b0});
    p = good_bit(1'b1);
    p.last = 1'b1;
    send_pulse(p);
    send_frame(good_header(), 16'h0003, 16'h0000, 3, -1);
    wait_idle();
  endtask

  // Full frames at reset timing: data extremes, window edges, error placement,
  // one pulse short, and pulses past the command.
  task automatic test_frame_rules();
    send_frame(good_header(), 16'h0000, 16'hffff, 34, -1);
    send_frame(good_header(), 16'hffff, 16'h0000, 34, -1);
    send_frame(good_header(), 16'ha5c3, 16'h5a3c, 34, -1);
    // 9000 +/- 20 us and 4500 +/- 20 us: just inside, then on each edge
    send_frame(pulse_of(15'd7185, 15'd3585), 16'($urandom), 16'($urandom), 34, -1);
    send_frame(pulse_of(15'd7215, 15'd3615), 16'($urandom), 16'($urandom), 34, -1);
    send_frame(pulse_of(15'd7184, 15'd3600), 16'($urandom), 16'($urandom), 34, -1);
    send_frame(pulse_of(15'd7216, 15'd3600), 16'($urandom), 16'($urandom), 34, -1);
    send_frame(pulse_of(15'd7200, 15'd3584), 16'($urandom), 16'($urandom), 34, -1);
    send_frame(pulse_of(15'd7200, 15'd3616), 16'($urandom), 16'($urandom), 34, -1);
    // header error, then bit errors at the first and the last data pulse
    send_frame(good_header(), 16'($urandom), 16'($urandom), 34, 0);
    send_frame(good_header(), 16'($urandom), 16'($urandom), 34, 1);
    send_frame(good_header(), 16'($urandom), 16'($urandom), 34, 32);
    // all noise: first error must stick
    send_noise(34);
    // one pulse short of a full frame, then a long one
    send_frame(good_header(), 16'hffff, 16'hffff, 33, -1);
    send_frame(good_header(), 16'($urandom), 16'($urandom), 50, -1);
    wait_idle();
  endtask

  // Each corner register set with a clean, a broken and a short frame, then noise.
  task automatic test_timing_corners();
    timing_set_e corner_sets[4];
    corner_sets = '{TS_INVERTED, TS_TIGHT, TS_EXTREME, TS_LOW};
    foreach (corner_sets[k]) begin
      apply_timing(corner_sets[k]);
      send_frame(good_header(), 16'($urandom), 16'($urandom), 34, -1);
      send_frame(good_header(), 16'($urandom), 16'($urandom), 35, $urandom_range(0, 32));
      send_frame(good_header(), 16'($urandom), 16'($urandom), 2, -1);
      send_noise(3);
      wait_idle();
    end
  endtask

  // Receiver holds off while single-pulse frames keep coming, so the block
  // fills up and has to drop tready.
  task automatic test_backpressure();
    pulse_t p;
    tx_steady   = 1'b1;
    rx_hold_req = HoldCycles;
    repeat (40) begin
      p = noise_pulse();
      p.last = 1'b1;
      send_pulse(p);
    end
    tx_steady = 1'b0;
    wait_idle();
  endtask

  // Mostly well-formed frames with random data, some broken, short or noise,
  // under a register set that changes every few frames.
  task automatic test_random_traffic();
    int left_in_set, pick;
    left_in_set = 0;
    while (pulses_sent < ItemTarget) begin
      if (left_in_set == 0) begin
        wait_idle();
        case ($urandom_range(0, 9))
          0: apply_timing(TS_DEFAULT);
          1: apply_timing(TS_INVERTED);
          2: apply_timing(TS_LOW);
          3: apply_timing(TS_TIGHT);
          default: apply_timing(TS_RANDOM);
        endcase
        left_in_set = $urandom_range(4, 10);
      end
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_frame(good_header(), 16'($urandom), 16'($urandom), $urandom_range(34, 38), -1);
      end else if (pick < 80) begin
        send_frame(good_header(), 16'($urandom), 16'($urandom), $urandom_range(34, 36),
                   $urandom_range(0, 33));
      end else if (pick < 90) begin
        send_frame(good_header(), 16'($urandom), 16'($urandom), $urandom_range(1, 33), -1);
      end else begin
        send_noise($urandom_range(1, 6));
      end
      left_in_set--;
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: cycles through always-ready, random and fixed-pattern stalls;
  // a test can ask for one long hold-off.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(0, 2);
      rx_mode_left = $urandom_range(50, 400);
      rx_pat       = 8'($urandom) | 8'h01;  // never all stalls
    end else begin
      rx_mode_left--;
    end
    rx_cyc++;
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 9) >= 3);
        default: m_axis_tready <= rx_pat[rx_cyc % 8];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: every output beat against the oldest decoded frame.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    frame_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: result beat with no frame pending: status %0d addr %h cmd %h",
                 $time, m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16]);
        mismatches++;
      end else begin
        want = decoded_q.pop_front();
        results_checked++;
        status_seen[int'(want.status)]++;
        if (m_axis_tuser !== want.status) begin
          $display("%0t: status mismatch: expected %0d, got %0d",
                   $time, want.status, m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tdata[15:0] !== want.address) begin
          $display("%0t: address mismatch: expected %h, got %h",
                   $time, want.address, m_axis_tdata[15:0]);
          mismatches++;
        end
        if (m_axis_tdata[31:16] !== want.command) begin
          $display("%0t: command mismatch: expected %h, got %h",
                   $time, want.command, m_axis_tdata[31:16]);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: too long without any beat or register write means a hang.
  int quiet_cycles;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: watchdog: nothing moved for %0d cycles, %0d frames outstanding",
                 $time, quiet_cycles, decoded_q.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    dec_cfg = CfgReset;
    clear_frame();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_short_frames();
    test_frame_rules();
    test_timing_corners();
    test_backpressure();
    test_random_traffic();

    $display("Run covered %0d pulse beats under %0d register sets, %0d frames checked",
             pulses_sent, settings_applied, results_checked);
    $display("Frame status mix: ok %0d, short %0d, bad header %0d, bad bit %0d; %0d mismatches",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
